[src/pdcc_pkg.sv]
package pdcc_pkg;

  localparam int unsigned TimeBytes     = 4;
  localparam int unsigned TimeIdxW      = $clog2(TimeBytes);
  localparam int unsigned TimeW         = 8 * TimeBytes;
  localparam int unsigned MaxPayloadDef = 255;

  // frame position, one-hot
  typedef enum logic [5:0] {
    PosIdle = 6'b000001,
    PosLen  = 6'b000010,
    PosTime = 6'b000100,
    PosCkLo = 6'b001000,
    PosCkHi = 6'b010000,
    PosData = 6'b100000
  } pos_e;

  typedef struct packed {
    logic             payload_valid;
    logic [7:0]       payload_byte;
    logic [7:0]       payload_index;
    logic             last;
    logic [7:0]       packet_id;
    logic [7:0]       payload_length;
    logic [TimeW-1:0] time_stamp;
    logic             checksum_ok;
  } result_t;

endpackage

[src/pdcc_parser.sv]
module pdcc_parser #(
  parameter int unsigned MaxPayload = pdcc_pkg::MaxPayloadDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  logic [7:0]        byte_i,
  input  logic              sop_i,
  output logic              produce_o,
  output pdcc_pkg::result_t res_o
);

  pdcc_pkg::pos_e                  pos_q, pos_d;
  logic [pdcc_pkg::TimeIdxW-1:0]   time_idx_q, time_idx_d;
  logic [7:0]                      sum_lo_q, sum_lo_d, sum_hi_q, sum_hi_d;
  logic [7:0]                      id_q, id_d, len_q, len_d, cnt_q, cnt_d;
  logic [pdcc_pkg::TimeW-1:0]      time_q, time_d;
  logic [15:0]                     rx_sum_q, rx_sum_d;
  logic [7:0]                      acc_lo, acc_hi, cnt_inc;
  logic                            sum_match;

  // running sums with the current byte added
  assign acc_lo  = sum_lo_q + byte_i;
  assign acc_hi  = sum_hi_q + acc_lo;
  assign cnt_inc = cnt_q + 8'd1;

  always_comb begin
    pos_d      = pos_q;
    time_idx_d = time_idx_q;
    sum_lo_d   = sum_lo_q;
    sum_hi_d   = sum_hi_q;
    id_d       = id_q;
    len_d      = len_q;
    cnt_d      = cnt_q;
    time_d     = time_q;
    rx_sum_d   = rx_sum_q;
    produce_o  = 1'b0;
    res_o      = '0;
    sum_match  = 1'b0;

    if (sop_i) begin
      sum_lo_d   = byte_i;
      sum_hi_d   = byte_i;
      id_d       = byte_i;
      len_d      = '0;
      time_d     = '0;
      rx_sum_d   = '0;
      cnt_d      = '0;
      time_idx_d = '0;
      pos_d      = pdcc_pkg::PosLen;
    end else begin
      unique case (pos_q)
        pdcc_pkg::PosLen: begin
          if (byte_i > 8'(MaxPayload)) begin
            pos_d = pdcc_pkg::PosIdle;
          end else begin
            len_d    = byte_i;
            sum_lo_d = acc_lo;
            sum_hi_d = acc_hi;
            pos_d    = pdcc_pkg::PosTime;
          end
        end
        pdcc_pkg::PosTime: begin
          time_d[8*time_idx_q +: 8] = byte_i;
          sum_lo_d   = acc_lo;
          sum_hi_d   = acc_hi;
          time_idx_d = time_idx_q + 1'b1;
          if (time_idx_q == pdcc_pkg::TimeIdxW'(pdcc_pkg::TimeBytes - 1)) begin
            pos_d = pdcc_pkg::PosCkLo;
          end
        end
        pdcc_pkg::PosCkLo: begin
          rx_sum_d[7:0] = byte_i;
          pos_d         = pdcc_pkg::PosCkHi;
        end
        pdcc_pkg::PosCkHi: begin
          rx_sum_d[15:8] = byte_i;
          cnt_d          = '0;
          if (len_q == 8'd0) begin
            sum_match            = (sum_lo_q == rx_sum_q[7:0]) && (sum_hi_q == byte_i);
            produce_o            = 1'b1;
            res_o.last           = 1'b1;
            res_o.packet_id      = id_q;
            res_o.payload_length = len_q;
            res_o.time_stamp     = time_q;
            res_o.checksum_ok    = sum_match;
            pos_d                = pdcc_pkg::PosIdle;
          end else begin
            pos_d = pdcc_pkg::PosData;
          end
        end
        pdcc_pkg::PosData: begin
          sum_lo_d            = acc_lo;
          sum_hi_d            = acc_hi;
          cnt_d               = cnt_inc;
          produce_o           = 1'b1;
          res_o.payload_valid = 1'b1;
          res_o.payload_byte  = byte_i;
          res_o.payload_index = cnt_q;
          if (cnt_inc >= len_q) begin
            sum_match            = (acc_lo == rx_sum_q[7:0]) && (acc_hi == rx_sum_q[15:8]);
            res_o.last           = 1'b1;
            res_o.packet_id      = id_q;
            res_o.payload_length = len_q;
            res_o.time_stamp     = time_q;
            res_o.checksum_ok    = sum_match;
            pos_d                = pdcc_pkg::PosIdle;
          end
        end
        default: begin
          pos_d = pdcc_pkg::PosIdle;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= pdcc_pkg::PosIdle;
      time_idx_q <= '0;
      sum_lo_q   <= '0;
      sum_hi_q   <= '0;
      id_q       <= '0;
      len_q      <= '0;
      cnt_q      <= '0;
      time_q     <= '0;
      rx_sum_q   <= '0;
    end else if (fire_i) begin
      pos_q      <= pos_d;
      time_idx_q <= time_idx_d;
      sum_lo_q   <= sum_lo_d;
      sum_hi_q   <= sum_hi_d;
      id_q       <= id_d;
      len_q      <= len_d;
      cnt_q      <= cnt_d;
      time_q     <= time_d;
      rx_sum_q   <= rx_sum_d;
    end
  end

endmodule

[src/pdcc_out_reg.sv]
module pdcc_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  pdcc_pkg::result_t res_i,
  input  logic              out_ready_i,
  output logic              can_load_o,
  output logic              out_valid_o,
  output pdcc_pkg::result_t res_o
);

  logic              valid_q, valid_d;
  pdcc_pkg::result_t res_q;

  assign can_load_o = !valid_q || out_ready_i;
  assign valid_d    = load_i || (valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

[src/packet_deframer_checksum_check.sv]
// Packet deframer with Fletcher-16 (mod 256) checksum check. Each input beat is one
// received byte; start_of_packet_i marks the frame id byte. A frame is id, length, four
// little-endian timestamp bytes, checksum low (sum1) and high (sum2), then length payload
// bytes. Header and checksum bytes give no output beat; each payload byte gives one beat
// with its index, and the final byte (the high checksum byte for an empty payload) also
// carries last, id, length, timestamp and checksum_ok. A start flag mid-frame drops the
// partial frame, a length above MaxPayload drops the frame, and bytes outside a frame are
// ignored. Throughput is one byte per clock while the output does not stall: a byte
// lands in the input register, the parser settles it combinationally (two 8-bit adds
// and a position step) and its result goes to the output register. Stalls on the output
// side back up through the input register.
module packet_deframer_checksum_check #(
  parameter int unsigned MaxPayload = pdcc_pkg::MaxPayloadDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [7:0]                  rx_byte_i,
  input  logic                        start_of_packet_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        payload_valid_o,
  output logic [7:0]                  payload_byte_o,
  output logic [7:0]                  payload_index_o,
  output logic                        last_o,
  output logic [7:0]                  packet_id_o,
  output logic [7:0]                  payload_length_o,
  output logic [pdcc_pkg::TimeW-1:0]  time_stamp_o,
  output logic                        checksum_ok_o
);

  // input register
  logic       in_vld_q;
  logic [7:0] byte_q;
  logic       sop_q;

  logic              produce;
  logic              can_load;
  logic              advance;
  pdcc_pkg::result_t res_comb;
  pdcc_pkg::result_t res_out;

  // advance the held byte unless it makes a beat and the output slot is full
  assign advance    = in_vld_q && (!produce || can_load);
  assign in_ready_o = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  // hold the payload while the byte waits
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      byte_q <= rx_byte_i;
      sop_q  <= start_of_packet_i;
    end
  end

  pdcc_parser #(
    .MaxPayload(MaxPayload)
  ) u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (advance),
    .byte_i   (byte_q),
    .sop_i    (sop_q),
    .produce_o(produce),
    .res_o    (res_comb)
  );

  pdcc_out_reg u_out_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (advance && produce),
    .res_i      (res_comb),
    .out_ready_i(out_ready_i),
    .can_load_o (can_load),
    .out_valid_o(out_valid_o),
    .res_o      (res_out)
  );

  assign payload_valid_o  = res_out.payload_valid;
  assign payload_byte_o   = res_out.payload_byte;
  assign payload_index_o  = res_out.payload_index;
  assign last_o           = res_out.last;
  assign packet_id_o      = res_out.packet_id;
  assign payload_length_o = res_out.payload_length;
  assign time_stamp_o     = res_out.time_stamp;
  assign checksum_ok_o    = res_out.checksum_ok;

endmodule
